FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions with reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nfcc_pkg.sv
// ----------------------------------------------------------------------------
// nfcc_pkg
// Types and constants for the sentence checksum checker.
// ----------------------------------------------------------------------------
package nfcc_pkg;

    // Frame length, counting the start character, at which a frame is dropped.
    localparam int MAX_FRAME = 256;
    localparam int FLEN_W    = $clog2(MAX_FRAME);

    localparam logic [FLEN_W:0] FRAME_LIMIT = (FLEN_W + 1)'(MAX_FRAME);

    localparam logic [7:0] CH_START    = 8'h24;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [2:0] TRAILER_LEN = 3'd4;

    // Bit 4 of a decoded digit flags a character that is not hex.
    localparam logic [4:0] HEX_NONE = 5'h10;

    typedef logic [FLEN_W-1:0] flen_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_TRAILER
    } phase_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c >= 8'h30 && c <= 8'h39)
            v = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

endpackage

FILE: rtl/nmea_frame_checksum_checker.sv
// ----------------------------------------------------------------------------
// nmea_frame_checksum_checker: sentence framing and checksum check per byte
// Byte and result are each registered; one byte per cycle unless out_stall holds.
// The rate is set by the per-byte XOR and frame state update in a single pass.
// Reset clears the frame state, the good-frame count and both valid flags.
// ----------------------------------------------------------------------------
module nmea_frame_checksum_checker
    import nfcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_done,
    output logic        checksum_ok,
    output logic [7:0]  computed_checksum,
    output logic [7:0]  received_checksum,
    output logic [15:0] good_frames
);

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic [7:0]  held_xor_reg, held_xor_next;
    logic [2:0]  trailer_count_reg, trailer_count_next;
    logic [7:0]  first_hex_reg, first_hex_next;
    logic [7:0]  second_hex_reg, second_hex_next;
    flen_t       frame_length_reg, frame_length_next;
    logic [15:0] good_count_reg, good_count_next;

    logic        frame_done_reg, frame_done_next;
    logic        checksum_ok_reg, checksum_ok_next;
    logic [7:0]  computed_reg, computed_next;
    logic [7:0]  received_reg, received_next;

    logic          advance;
    logic          proc;
    logic          is_start;
    logic          is_star;
    logic          active;
    logic [FLEN_W:0] len_inc;
    logic [2:0]    trl_inc;
    logic          too_long;
    logic          complete;
    logic [4:0]    h1;
    logic [4:0]    h2;
    logic [7:0]    recv_dec;
    logic          match;

    // The output register frees up when it is empty or its transaction completes.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign proc     = s1_valid_reg && advance;

    assign is_start = (s1_byte_reg == CH_START);
    assign is_star  = (s1_byte_reg == CH_STAR);
    assign active   = (phase_reg != PH_IDLE) && !is_start;
    assign len_inc  = {1'b0, frame_length_reg} + 1'b1;
    assign trl_inc  = trailer_count_reg + 3'd1;
    assign too_long = active && (len_inc >= FRAME_LIMIT);
    assign complete = active && !is_star && (phase_reg == PH_TRAILER)
                      && (trl_inc >= TRAILER_LEN) && !too_long;

    assign h1 = hex_value(first_hex_reg);
    assign h2 = hex_value(second_hex_reg);

    always_comb
    begin
        if (h1[4])
            recv_dec = 8'h00;
        else if (h2[4])
            recv_dec = {4'h0, h1[3:0]};
        else
            recv_dec = {h1[3:0], h2[3:0]};
    end

    assign match = (recv_dec == held_xor_reg);

    // Next frame phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (proc)
        begin
            if (is_start)
                phase_next = PH_BODY;
            else if (active)
            begin
                if (too_long || complete)
                    phase_next = PH_IDLE;
                else if (is_star)
                    phase_next = PH_TRAILER;
            end
        end
    end

    // Datapath state and result.
    always_comb
    begin
        running_xor_next   = running_xor_reg;
        held_xor_next      = held_xor_reg;
        trailer_count_next = trailer_count_reg;
        first_hex_next     = first_hex_reg;
        second_hex_next    = second_hex_reg;
        frame_length_next  = frame_length_reg;
        good_count_next    = good_count_reg;
        if (proc)
        begin
            if (is_start)
            begin
                running_xor_next   = 8'h00;
                trailer_count_next = 3'd0;
                frame_length_next  = flen_t'(1);
            end
            else if (active)
            begin
                frame_length_next = len_inc[FLEN_W-1:0];
                running_xor_next  = running_xor_reg ^ s1_byte_reg;
                if (is_star)
                begin
                    held_xor_next      = running_xor_reg;
                    trailer_count_next = 3'd0;
                end
                else if (phase_reg == PH_TRAILER)
                begin
                    trailer_count_next = trl_inc;
                    if (trl_inc == 3'd1)
                        first_hex_next = s1_byte_reg;
                    else if (trl_inc == 3'd2)
                        second_hex_next = s1_byte_reg;
                end
                if (too_long || complete)
                begin
                    trailer_count_next = 3'd0;
                    frame_length_next  = '0;
                end
                if (complete && match && (good_count_reg != 16'hFFFF))
                    good_count_next = good_count_reg + 16'd1;
            end
        end
    end

    always_comb
    begin
        frame_done_next  = complete;
        checksum_ok_next = complete && match;
        computed_next    = complete ? held_xor_reg : 8'h00;
        received_next    = complete ? recv_dec : 8'h00;
    end

    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= PH_IDLE;
            running_xor_reg   <= 8'h00;
            held_xor_reg      <= 8'h00;
            trailer_count_reg <= 3'd0;
            first_hex_reg     <= 8'h00;
            second_hex_reg    <= 8'h00;
            frame_length_reg  <= '0;
            good_count_reg    <= 16'h0000;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            phase_reg         <= phase_next;
            running_xor_reg   <= running_xor_next;
            held_xor_reg      <= held_xor_next;
            trailer_count_reg <= trailer_count_next;
            first_hex_reg     <= first_hex_next;
            second_hex_reg    <= second_hex_next;
            frame_length_reg  <= frame_length_next;
            good_count_reg    <= good_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            s1_byte_reg <= data_byte;
        if (proc)
        begin
            frame_done_reg  <= frame_done_next;
            checksum_ok_reg <= checksum_ok_next;
            computed_reg    <= computed_next;
            received_reg    <= received_next;
        end
    end

    // The count only moves when a byte is processed, so it always matches the
    // transaction held in the output register.
    assign out_valid         = out_valid_reg;
    assign frame_done        = frame_done_reg;
    assign checksum_ok       = checksum_ok_reg;
    assign computed_checksum = computed_reg;
    assign received_checksum = received_reg;
    assign good_frames       = good_count_reg;

endmodule

FILE: rtl/nfcc_checker.sv
// ----------------------------------------------------------------------------
// nfcc_checker
// Port-level checks for the sentence checksum checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfcc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        frame_done,
    input logic        checksum_ok,
    input logic [7:0]  computed_checksum,
    input logic [7:0]  received_checksum,
    input logic [15:0] good_frames
);

    logic        ok_result;
    logic        empty_result;
    logic        out_held;
    logic        sums_equal;
    logic        fields_clear;
    logic [33:0] result_bits;

    assign ok_result    = out_valid && checksum_ok;
    assign empty_result = out_valid && !frame_done;
    assign out_held     = out_valid && out_stall;
    assign sums_equal   = (computed_checksum == received_checksum);
    assign fields_clear = (computed_checksum == 8'h00) && (received_checksum == 8'h00)
                          && !checksum_ok;
    assign result_bits  = {frame_done, checksum_ok, computed_checksum, received_checksum,
                           good_frames};

    `ASSERT_SAME(a_ok_needs_done, ok_result, frame_done, "checksum_ok without frame_done")

    `ASSERT_SAME(a_ok_means_match, ok_result, sums_equal, "checksum_ok with mismatched sums")

    `ASSERT_SAME(a_idle_fields_zero, empty_result, fields_clear, "nonzero fields, no frame")

    `ASSERT_NEXT(a_count_monotonic, 1'b1, good_frames >= $past(good_frames), "count decreased")

    `ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(result_bits), "stalled result moved")

endmodule

bind nmea_frame_checksum_checker nfcc_checker u_nfcc_checker (.*);

FILE: sim/nmea_frame_checksum_checker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_frame_checksum_checker_test
// Drives byte streams of NMEA-style sentences into the checker. The streams
// hold good, corrupted, truncated and oversized frames, repeated asterisks,
// and noise between frames. A scoreboard predicts the per-byte result and
// compares every output transaction field by field. Both handshakes idle at
// random.
// ----------------------------------------------------------------------------
package nfcc_check_pkg;
    import nfcc_pkg::*;

    typedef struct packed {
        logic        done;
        logic        ok;
        logic [7:0]  comp;
        logic [7:0]  recv;
        logic [15:0] good;
    } sum_result_t;

    // Hex digit value in the low nibble; HEX_NONE when the byte is not a digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c >= 8'h30 && c <= 8'h39)
            v = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 5'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 5'(c - 8'h57);
        return v;
    endfunction

    class checksum_scoreboard;
        phase_t      frame_phase;
        logic [7:0]  body_xor;
        logic [7:0]  star_xor;
        logic [7:0]  first_ch;
        logic [7:0]  second_ch;
        int          trail_cnt;
        int          frame_len;
        logic [15:0] good_total;
        sum_result_t expected_results[$];
        int          failures;

        function new();
            frame_phase = PH_IDLE;
            body_xor    = '0;
            star_xor    = '0;
            first_ch    = '0;
            second_ch   = '0;
            trail_cnt   = 0;
            frame_len   = 0;
            good_total  = '0;
            failures    = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_byte(input logic [7:0] b);
            sum_result_t r;
            logic [4:0]  hi;
            logic [4:0]  lo;
            r = '0;
            if (b == CH_START) begin
                frame_phase = PH_BODY;
                body_xor    = '0;
                trail_cnt   = 0;
                frame_len   = 1;
            end
            else if (frame_phase != PH_IDLE) begin
                frame_len++;
                if (b == CH_STAR) begin
                    star_xor    = body_xor;
                    body_xor    = body_xor ^ b;
                    trail_cnt   = 0;
                    frame_phase = PH_TRAILER;
                end
                else begin
                    body_xor = body_xor ^ b;
                    if (frame_phase == PH_TRAILER) begin
                        trail_cnt++;
                        if (trail_cnt == 1)
                            first_ch = b;
                        else if (trail_cnt == 2)
                            second_ch = b;
                    end
                end

                // An oversized frame is dropped even on its completing byte.
                if (frame_len >= MAX_FRAME) begin
                    frame_phase = PH_IDLE;
                    trail_cnt   = 0;
                    frame_len   = 0;
                end
                else if (frame_phase == PH_TRAILER && trail_cnt >= int'(TRAILER_LEN)) begin
                    hi = nibble_of(first_ch);
                    lo = nibble_of(second_ch);
                    if (hi[4])
                        r.recv = '0;
                    else if (lo[4])
                        r.recv = {4'h0, hi[3:0]};
                    else
                        r.recv = {hi[3:0], lo[3:0]};
                    r.comp = star_xor;
                    r.done = 1'b1;
                    r.ok   = (r.recv == r.comp);
                    if (r.ok && good_total != 16'hFFFF)
                        good_total++;
                    frame_phase = PH_IDLE;
                    trail_cnt   = 0;
                    frame_len   = 0;
                end
            end
            r.good = good_total;
            expected_results.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                failures++;
            end
        endfunction

        function void check_result(input sum_result_t got);
            sum_result_t want;
            if (expected_results.size() == 0) begin
                $error("result transaction with no byte waiting for it");
                failures++;
            end
            else begin
                want = expected_results.pop_front();
                compare_field("frame_done", 16'(want.done), 16'(got.done));
                compare_field("checksum_ok", 16'(want.ok), 16'(got.ok));
                compare_field("computed_checksum", 16'(want.comp), 16'(got.comp));
                compare_field("received_checksum", 16'(want.recv), 16'(got.recv));
                compare_field("good_frames", want.good, got.good);
            end
        endfunction

        function bit all_clear();
            if (expected_results.size() != 0) begin
                $error("%0d results never arrived", expected_results.size());
                failures++;
            end
            return failures == 0;
        endfunction
    endclass

endpackage

module nmea_frame_checksum_checker_test;
    import nfcc_pkg::*;
    import nfcc_check_pkg::*;

    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam logic [7:0] CR          = 8'h0D;
    localparam logic [7:0] LF          = 8'h0A;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_FIRST,
        FRAME_BAD_SECOND,
        FRAME_RESTAR,
        FRAME_CUT
    } frame_kind_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic        frame_done;
    logic        checksum_ok;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
    logic [15:0] good_frames;

    checksum_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int items_sent;
    int cycle_count;

    nmea_frame_checksum_checker u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .frame_done        (frame_done),
        .checksum_ok       (checksum_ok),
        .computed_checksum (computed_checksum),
        .received_checksum (received_checksum),
        .good_frames       (good_frames)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Both handshakes are observed here so that each byte is predicted
    // before any result at the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_byte(data_byte);
            if (out_valid && !out_stall)
                sb.check_result({frame_done, checksum_ok, computed_checksum,
                                 received_checksum, good_frames});
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [7:0] body_byte();
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 9) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(32, 126));
        end while (c == CH_START || c == CH_STAR);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + 8'(n);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [4:0] v;
        do begin
            c = 8'($urandom_range(0, 255));
            v = nibble_of(c);
        end while (!v[4] || c == CH_START || c == CH_STAR);
        return c;
    endfunction

    // The valid stays high after a transaction; the next call either replaces
    // the byte or lowers the valid for a gap, in the same time step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic send_frame(input frame_kind_t kind, input int body_len);
        logic [7:0] acc;
        logic [7:0] c;
        logic [7:0] sum;
        int         n;
        acc = '0;
        send_byte(CH_START);
        for (int i = 0; i < body_len; i++) begin
            c   = body_byte();
            acc = acc ^ c;
            send_byte(c);
        end
        if (kind == FRAME_CUT) begin
            if ($urandom_range(0, 1)) begin
                send_byte(CH_STAR);
                repeat ($urandom_range(0, 3))
                    send_byte(hex_char(4'($urandom_range(0, 15))));
            end
        end
        else begin
            // An earlier asterisk and the bytes after it fall into the final snapshot.
            if (kind == FRAME_RESTAR) begin
                acc = acc ^ CH_STAR;
                send_byte(CH_STAR);
                n = $urandom_range(0, 3);
                repeat (n) begin
                    c   = body_byte();
                    acc = acc ^ c;
                    send_byte(c);
                end
            end
            send_byte(CH_STAR);
            sum = acc;
            if (kind == FRAME_BAD_SUM)
                sum = acc ^ 8'($urandom_range(1, 255));
            if (kind == FRAME_BAD_FIRST) begin
                send_byte(non_hex_char());
                send_byte(hex_char(4'($urandom_range(0, 15))));
            end
            else if (kind == FRAME_BAD_SECOND) begin
                send_byte(hex_char(sum[7:4]));
                send_byte(non_hex_char());
            end
            else begin
                send_byte(hex_char(sum[7:4]));
                send_byte(hex_char(sum[3:0]));
            end
            send_byte($urandom_range(0, 3) != 0 ? CR : body_byte());
            send_byte($urandom_range(0, 3) != 0 ? LF : body_byte());
        end
    endtask

    task automatic random_traffic(input int item_target);
        int          pick;
        int          body_len;
        frame_kind_t kind;
        items_sent = 0;
        while (items_sent < item_target) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 29) == 0)
                body_len = $urandom_range(MAX_FRAME - 16, MAX_FRAME + 4);
            else
                body_len = $urandom_range(0, 20);
            if (pick < 90) begin
                if (pick < 45)
                    kind = FRAME_GOOD;
                else if (pick < 55)
                    kind = FRAME_BAD_SUM;
                else if (pick < 62)
                    kind = FRAME_BAD_FIRST;
                else if (pick < 69)
                    kind = FRAME_BAD_SECOND;
                else if (pick < 79)
                    kind = FRAME_RESTAR;
                else
                    kind = FRAME_CUT;
                send_frame(kind, body_len);
            end
            else begin
                // Noise: ignored between frames, frame content after a cut frame.
                repeat ($urandom_range(1, 4)) begin
                    logic [7:0] c;
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_START);
                    send_byte(c);
                end
            end
        end
    endtask

    initial
    begin
        int drain;
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 0;
        hold_left     = 0;
        items_sent    = 0;
        cycle_count   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bytes outside any frame are ignored.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_STAR);
        send_byte(8'h41);
        // Checksum FF in upper and lower case, and an empty body.
        send_byte(CH_START); send_byte(8'hFF); send_byte(CH_STAR);
        send_byte(8'h46); send_byte(8'h46); send_byte(CR); send_byte(LF);
        send_byte(CH_START); send_byte(8'hFF); send_byte(CH_STAR);
        send_byte(8'h66); send_byte(8'h66); send_byte(CR); send_byte(LF);
        send_byte(CH_START); send_byte(CH_STAR);
        send_byte(8'h30); send_byte(8'h30); send_byte(8'h00); send_byte(8'hFF);
        // First trailer character not hex, then only the second not hex.
        send_byte(CH_START); send_byte(8'h41); send_byte(CH_STAR);
        send_byte(8'h47); send_byte(8'h31); send_byte(CR); send_byte(LF);
        send_byte(CH_START); send_byte(8'h41); send_byte(CH_STAR);
        send_byte(8'h34); send_byte(8'h5A); send_byte(CR); send_byte(LF);
        send_frame(FRAME_RESTAR, 3);
        send_frame(FRAME_BAD_SUM, 5);
        send_frame(FRAME_CUT, 4);
        // Oversized frames: one completing exactly at the limit is dropped,
        // one a byte shorter completes, and a body with no asterisk is dropped.
        send_frame(FRAME_GOOD, MAX_FRAME - 6);
        send_frame(FRAME_GOOD, MAX_FRAME - 7);
        send_byte(CH_START);
        repeat (MAX_FRAME + 3)
            send_byte(body_byte());

        send_idle_pct = 34;
        recv_idle_pct = 50;
        random_traffic(350);
        send_idle_pct = 50;
        recv_idle_pct = 34;
        random_traffic(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(250);

        // Hold the receiver off while the sender keeps offering bytes.
        hold_request = 400;
        random_traffic(200);
        // Pause the sender until every result has been delivered.
        stop_sending();
        while (sb.pending() != 0)
            @(posedge clk);
        send_idle_pct = 20;
        recv_idle_pct = 20;
        random_traffic(100);
        stop_sending();

        drain = 0;
        while (sb.pending() != 0 && drain < 2000) begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (sb.all_clear())
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
